// ===== rtl/sswst_pkg.sv =====
// Shared types and constants for the sensor sample window statistics block.
// No dependencies.
package sswst_pkg;

  localparam int RING_DEPTH = 256;
  localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int COUNT_W    = $clog2(RING_DEPTH + 1);
  localparam int SUM_W      = 32 + COUNT_W;
  localparam int DVD_W      = SUM_W - 1 + 8;
  localparam int STEP_W     = $clog2(DVD_W);

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_FLUSH = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] RS_OK = 2'd0;

  localparam logic REG_RING_LENGTH = 1'b0;
  localparam logic REG_ERROR_LIMIT = 1'b1;

  localparam int FLAG_WRAP = 0;

  typedef struct packed {
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_slot;
    logic [31:0]        wr_data;
    logic [SLOT_W-1:0]  start;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] len;
    logic [3:0]         flags;
    logic               healthy;
    logic [31:0]        good;
    logic [31:0]        failed;
    logic [31:0]        run;
    logic [1:0]         kind;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_WALK,
    ST_DIV,
    ST_OUT
  } back_state_t;

endpackage

// ===== rtl/sswst_front.sv =====
// Front end: config registers, item classification, counters and ring pointers.
// Depends on sswst_pkg; emits one job per accepted item.
module sswst_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_take,
  input  logic [1:0]           in_opcode,
  input  logic [1:0]           in_read_status,
  input  logic signed [31:0]   in_sample_value,
  output sswst_pkg::job_t      job
);
  import sswst_pkg::*;

  logic [8:0]         ring_length_r;
  logic [15:0]        error_limit_r;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [COUNT_W-1:0] held_r, held_nxt;
  logic [3:0]         flags_r, flags_nxt;
  logic [31:0]        good_r, good_nxt, failed_r, failed_nxt, run_r, run_nxt;
  logic [1:0]         kind_r, kind_nxt;

  logic [COUNT_W-1:0] len, ws, hc;
  logic [COUNT_W:0]   start_tmp;
  logic [COUNT_W-1:0] start_w;

  always_comb begin
    if (ring_length_r == 9'd0) len = COUNT_W'(1);
    else if (32'(ring_length_r) > RING_DEPTH) len = COUNT_W'(RING_DEPTH);
    else len = COUNT_W'(ring_length_r);
    ws = (COUNT_W'(slot_r) >= len) ? '0 : COUNT_W'(slot_r);
    hc = (held_r > len) ? len : held_r;
  end

  always_comb begin
    logic [COUNT_W-1:0] ws_n;
    ws_n       = ws;
    held_nxt   = hc;
    flags_nxt  = flags_r;
    good_nxt   = good_r;
    failed_nxt = failed_r;
    run_nxt    = run_r;
    kind_nxt   = kind_r;
    case (in_opcode)
      OP_READ: begin
        if (in_read_status == RS_OK) begin
          if (hc == len) flags_nxt[FLAG_WRAP] = 1'b1;
          else held_nxt = hc + COUNT_W'(1);
          ws_n     = (ws + COUNT_W'(1) == len) ? '0 : ws + COUNT_W'(1);
          good_nxt = good_r + 32'd1;
          run_nxt  = '0;
        end else begin
          flags_nxt[in_read_status] = 1'b1;
          kind_nxt   = in_read_status;
          failed_nxt = failed_r + 32'd1;
          if (run_r != '1) run_nxt = run_r + 32'd1;
        end
      end
      OP_FLUSH: begin
        ws_n     = '0;
        held_nxt = '0;
      end
      OP_CLEAR: flags_nxt = '0;
      default: ;
    endcase
    slot_nxt = SLOT_W'(ws_n);
    // oldest held entry, one wrap at most
    start_tmp = {1'b0, ws_n} + {1'b0, len} - {1'b0, held_nxt};
    if (start_tmp >= {1'b0, len}) start_tmp = start_tmp - {1'b0, len};
    start_w = start_tmp[COUNT_W-1:0];
  end

  always_comb begin
    job.wr_en   = (in_opcode == OP_READ) && (in_read_status == RS_OK);
    job.wr_slot = SLOT_W'(ws);
    job.wr_data = in_sample_value;
    job.start   = SLOT_W'(start_w);
    job.count   = held_nxt;
    job.len     = len;
    job.flags   = flags_nxt;
    job.healthy = run_nxt <= {16'd0, error_limit_r};
    job.good    = good_nxt;
    job.failed  = failed_nxt;
    job.run     = run_nxt;
    job.kind    = kind_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_length_r <= 9'd256;
      error_limit_r <= 16'd3;
      slot_r        <= '0;
      held_r        <= '0;
      flags_r       <= '0;
      good_r        <= '0;
      failed_r      <= '0;
      run_r         <= '0;
      kind_r        <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_RING_LENGTH) begin
        ring_length_r <= cfg_data[8:0];
        slot_r        <= '0;
        held_r        <= '0;
      end else begin
        error_limit_r <= cfg_data;
      end
    end else if (in_take) begin
      slot_r   <= slot_nxt;
      held_r   <= held_nxt;
      flags_r  <= flags_nxt;
      good_r   <= good_nxt;
      failed_r <= failed_nxt;
      run_r    <= run_nxt;
      kind_r   <= kind_nxt;
    end
  end

endmodule

// ===== rtl/sswst_queue.sv =====
// Two-entry job queue between front and back.
// Depends on sswst_pkg for the job type.
module sswst_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sswst_pkg::job_t push_job,
  input  logic            pop,
  output sswst_pkg::job_t pop_job,
  output logic            empty,
  output logic            full
);
  import sswst_pkg::*;

  job_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign empty   = (cnt_r == 2'd0);
  assign full    = (cnt_r == 2'd2);
  assign pop_job = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/sswst_back.sv =====
// Back end: sample ring memory, window walk, serial divider, output register.
// Depends on sswst_pkg; takes jobs from sswst_queue.
module sswst_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_empty,
  input  sswst_pkg::job_t       job_in,
  output logic                  job_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    out_latest_sample,
  output logic signed [31:0]    out_window_minimum,
  output logic signed [31:0]    out_window_maximum,
  output logic signed [39:0]    out_window_mean,
  output logic                  out_stats_valid,
  output logic [8:0]            out_sample_count,
  output logic [3:0]            out_sticky_flags,
  output logic                  out_healthy,
  output logic [31:0]           out_good_reads,
  output logic [31:0]           out_failed_reads,
  output logic [31:0]           out_error_run,
  output logic [1:0]            out_last_error_kind
);
  import sswst_pkg::*;

  back_state_t st_r, st_nxt;
  job_t        job_r;

  logic [31:0]        ring_mem [RING_DEPTH];
  logic [SLOT_W-1:0]  pos_r;
  logic [COUNT_W-1:0] issued_r;
  logic signed [31:0] rdata_r;
  logic               rd_vld_r, first_r;
  logic signed [31:0] min_r, max_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [DVD_W-1:0]   dvd_r, quo_r;
  logic [COUNT_W-1:0] rem_r;
  logic               neg_r;
  logic [STEP_W-1:0]  step_r;
  logic               out_valid_r;

  logic mem_we, mem_re, walk_done, out_load;
  logic [COUNT_W:0]   div_t;
  logic [SUM_W-1:0]   sum_mag;
  logic [DVD_W-1:0]   mean_w;

  assign out_valid = out_valid_r;
  assign walk_done = (issued_r == job_r.count) && !rd_vld_r;
  assign div_t     = {rem_r, dvd_r[DVD_W-1]};
  assign sum_mag   = sum_r[SUM_W-1] ? -sum_r : sum_r;
  assign mean_w    = neg_r ? -quo_r : quo_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (!job_empty) st_nxt = ST_WRITE;
      ST_WRITE: st_nxt = (job_r.count == '0) ? ST_OUT : ST_WALK;
      ST_WALK:  if (walk_done) st_nxt = ST_DIV;
      ST_DIV:   if (step_r == STEP_W'(DVD_W - 1)) st_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || !out_stall) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    job_pop  = (st_r == ST_IDLE) && !job_empty;
    mem_we   = (st_r == ST_WRITE) && job_r.wr_en;
    mem_re   = (st_r == ST_WALK) && (issued_r != job_r.count);
    out_load = (st_r == ST_OUT) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (mem_we) ring_mem[job_r.wr_slot] <= job_r.wr_data;
    if (mem_re) rdata_r <= ring_mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_vld_r <= 1'b0;
    else rd_vld_r <= mem_re;
  end

  always_ff @(posedge clk) begin
    if (job_pop) job_r <= job_in;
    case (st_r)
      ST_WRITE: begin
        pos_r    <= job_r.start;
        issued_r <= '0;
        first_r  <= 1'b1;
        sum_r    <= '0;
        min_r    <= '0;
        max_r    <= '0;
      end
      ST_WALK: begin
        if (mem_re) begin
          issued_r <= issued_r + COUNT_W'(1);
          pos_r    <= ({1'b0, pos_r} + COUNT_W'(1) == job_r.len) ?
                      '0 : pos_r + SLOT_W'(1);
        end
        if (rd_vld_r) begin
          first_r <= 1'b0;
          sum_r   <= sum_r + SUM_W'(rdata_r);
          if (first_r || rdata_r < min_r) min_r <= rdata_r;
          if (first_r || rdata_r > max_r) max_r <= rdata_r;
        end
        if (walk_done) begin
          dvd_r  <= {sum_mag[SUM_W-2:0], 8'd0};
          neg_r  <= sum_r[SUM_W-1];
          rem_r  <= '0;
          quo_r  <= '0;
          step_r <= '0;
        end
      end
      ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (div_t >= {1'b0, job_r.count}) begin
          rem_r <= COUNT_W'(div_t - {1'b0, job_r.count});
          quo_r <= {quo_r[DVD_W-2:0], 1'b1};
        end else begin
          rem_r <= div_t[COUNT_W-1:0];
          quo_r <= {quo_r[DVD_W-2:0], 1'b0};
        end
        dvd_r  <= dvd_r << 1;
        step_r <= step_r + STEP_W'(1);
      end
      default: ;
    endcase
  end

  // the last element walked is the newest sample
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (job_r.count == '0) begin
        out_latest_sample  <= '0;
        out_window_minimum <= '0;
        out_window_maximum <= '0;
        out_window_mean    <= '0;
      end else begin
        out_latest_sample  <= rdata_r;
        out_window_minimum <= min_r;
        out_window_maximum <= max_r;
        out_window_mean    <= mean_w[39:0];
      end
      out_stats_valid     <= job_r.count != '0;
      out_sample_count    <= 9'(job_r.count);
      out_sticky_flags    <= job_r.flags;
      out_healthy         <= job_r.healthy;
      out_good_reads      <= job_r.good;
      out_failed_reads    <= job_r.failed;
      out_error_run       <= job_r.run;
      out_last_error_kind <= job_r.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  a_walk_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_WALK && walk_done) |=> (st_r == ST_DIV))
    else $error("walk finished without entering divide");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_WALK) |-> (issued_r <= job_r.count))
    else $error("walk read past the held window");

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(st_r) == ST_OUT))
    else $error("result shown outside output state");

  a_no_read_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV) |-> !rd_vld_r)
    else $error("ring read still in flight during divide");

endmodule

// ===== rtl/sensor_sample_window_stats.sv =====
// Top level of the sensor sample window statistics block.
// Depends on sswst_pkg, sswst_front, sswst_queue and sswst_back.
//
// Input channel in_*: one item per transfer (opcode, read status, sample).
// The front updates counters, flags and ring pointers at the transfer and
// queues a job; in_stall rises only when the two-entry job queue is full.
// Result channel out_*: one result per item, held in an output register
// until a transfer with out_stall low. While the receiver stalls, the back
// end finishes the next job and waits; the front keeps taking items until
// the queue fills.
// Per item, the back end walks the held samples of the window (one ring
// memory read per cycle), then runs a 48-step restoring divider for the
// mean. The ring holds up to 256 entries; the back end works one job at
// a time.
// Config port cfg_*: always ready; index 0 ring_length (also flushes the
// ring), index 1 error_limit. Write only while the block is idle.
// Reset (rst_n low, synchronous) clears pointers, counters and flags and
// loads ring_length 256, error_limit 3. Ring memory is not cleared; only
// written entries are ever read.
module sensor_sample_window_stats (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_opcode,
  input  logic [1:0]          in_read_status,
  input  logic signed [31:0]  in_sample_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_latest_sample,
  output logic signed [31:0]  out_window_minimum,
  output logic signed [31:0]  out_window_maximum,
  output logic signed [39:0]  out_window_mean,
  output logic                out_stats_valid,
  output logic [8:0]          out_sample_count,
  output logic [3:0]          out_sticky_flags,
  output logic                out_healthy,
  output logic [31:0]         out_good_reads,
  output logic [31:0]         out_failed_reads,
  output logic [31:0]         out_error_run,
  output logic [1:0]          out_last_error_kind
);
  import sswst_pkg::*;

  job_t front_job, back_job;
  logic q_full, q_empty, q_pop, in_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_take   = in_valid && !q_full;

  sswst_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_take         (in_take),
    .in_opcode       (in_opcode),
    .in_read_status  (in_read_status),
    .in_sample_value (in_sample_value),
    .job             (front_job)
  );

  sswst_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_take),
    .push_job (front_job),
    .pop      (q_pop),
    .pop_job  (back_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  sswst_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .job_empty           (q_empty),
    .job_in              (back_job),
    .job_pop             (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_latest_sample   (out_latest_sample),
    .out_window_minimum  (out_window_minimum),
    .out_window_maximum  (out_window_maximum),
    .out_window_mean     (out_window_mean),
    .out_stats_valid     (out_stats_valid),
    .out_sample_count    (out_sample_count),
    .out_sticky_flags    (out_sticky_flags),
    .out_healthy         (out_healthy),
    .out_good_reads      (out_good_reads),
    .out_failed_reads    (out_failed_reads),
    .out_error_run       (out_error_run),
    .out_last_error_kind (out_last_error_kind)
  );

endmodule
